// ===== sv/hcbd_pkg.sv =====
// shared types, codes and helpers for the chunked body decoder
package hcbd_pkg;

    typedef enum logic [2:0] {
        PH_SIZE    = 3'd0,
        PH_DATA    = 3'd1,
        PH_DATA_CR = 3'd2,
        PH_DATA_LF = 3'd3,
        PH_TRAILER = 3'd4,
        PH_DONE    = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        ERR_NONE = 3'd0,
        ERR_LONG = 3'd1,
        ERR_BAD  = 3'd2,
        ERR_CRLF = 3'd3,
        ERR_OVF  = 3'd4
    } t_err;

    // line flag bit positions
    localparam int FL_EXT   = 0;
    localparam int FL_SPACE = 1;
    localparam int FL_CR    = 2;
    localparam int FL_BITS  = 3;

    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SEMI  = 8'h3b;

    localparam int CFG_BITS = 16;
    localparam logic [CFG_BITS-1:0] MAX_LINE_RESET = 16'd8192;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        case (c) inside
            [8'h30:8'h39]: h.val = 4'(c - 8'h30);
            [8'h61:8'h66]: h.val = 4'(c - 8'h57);
            [8'h41:8'h46]: h.val = 4'(c - 8'h37);
            default:       h.ok  = 1'b0;
        endcase
        return h;
    endfunction

endpackage

// ===== sv/http_chunked_body_decoder_top.sv =====
// http chunked transfer body decoder, one stream byte per word
// Takes one body byte per cycle, returns one result word per byte via two register stages (input
// word register, then result register), at a sustained rate of one word per clock while
// m_axis_tready is high, set by the state update between them. s_axis_tuser is the
// start-of-message flag that clears all parse state before its byte. Results carry the content
// byte with a valid flag in m_axis_tuser, tlast on the final byte of each chunk, the done flag and
// a sticky error code. The line length limit is written through the cfg channel, always ready.
module http_chunked_body_decoder_top #(
    parameter int SIZE_BITS     = 32,
    parameter int LINE_LEN_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write: max line length
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tuser,   // [0] start_message
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] body_byte, [8] done_res, [11:9] error_code, zero
    output logic        m_axis_tlast,   // chunk_end
    output logic        m_axis_tuser    // [0] body_valid
);

    localparam int CB = hcbd_pkg::CFG_BITS;
    localparam logic [CB-1:0] LINE_CAP = {CB{1'b1}} >> (CB - LINE_LEN_BITS);

    // configuration
    logic [CB-1:0] r_max_len;

    // input word register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_start;

    // parse state
    hcbd_pkg::t_phase             r_phase, n_phase, b_phase;
    hcbd_pkg::t_err               r_err, n_err, b_err;
    logic [LINE_LEN_BITS-1:0]     r_line, n_line, b_line, line_inc;
    logic [SIZE_BITS-1:0]         r_size, n_size, b_size;
    logic [SIZE_BITS-1:0]         r_remain, n_remain, b_remain;
    logic [hcbd_pkg::FL_BITS-1:0] r_flags, n_flags, b_flags;

    // result register
    logic       r_out_valid;
    logic       r_out_bvalid;
    logic [7:0] r_out_byte;
    logic       r_out_last;
    logic       r_out_done;
    logic [2:0] r_out_err;

    logic          o_bvalid, o_last;
    logic [7:0]    o_byte;
    logic          advance;
    logic [CB-1:0] limit;
    hcbd_pkg::t_hex hv;
    logic          prev_cr;

    assign o_cfg_ready   = 1'b1;
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign limit         = (r_max_len < LINE_CAP) ? r_max_len : LINE_CAP;
    assign hv            = hcbd_pkg::hex_decode(r_in_byte);

    always_comb begin
        if (r_in_start) begin
            b_phase  = hcbd_pkg::PH_SIZE;
            b_err    = hcbd_pkg::ERR_NONE;
            b_line   = '0;
            b_size   = '0;
            b_remain = '0;
            b_flags  = '0;
        end else begin
            b_phase  = r_phase;
            b_err    = r_err;
            b_line   = r_line;
            b_size   = r_size;
            b_remain = r_remain;
            b_flags  = r_flags;
        end
        n_phase  = b_phase;
        n_err    = b_err;
        n_line   = b_line;
        n_size   = b_size;
        n_remain = b_remain;
        n_flags  = b_flags;
        o_bvalid = 1'b0;
        o_byte   = 8'd0;
        o_last   = 1'b0;
        line_inc = b_line + LINE_LEN_BITS'(1);
        prev_cr  = b_flags[hcbd_pkg::FL_CR];

        if (b_err == hcbd_pkg::ERR_NONE) begin
            case (b_phase)
                hcbd_pkg::PH_SIZE, hcbd_pkg::PH_TRAILER: begin
                    if (CB'(b_line) >= limit) begin
                        n_err = hcbd_pkg::ERR_LONG;
                    end else begin
                        n_line = line_inc;
                        if (b_phase == hcbd_pkg::PH_SIZE) begin
                            if (prev_cr && r_in_byte == hcbd_pkg::CH_LF) begin
                                // spaces with no extension after them are not allowed
                                if (!b_flags[hcbd_pkg::FL_EXT] && b_flags[hcbd_pkg::FL_SPACE]) begin
                                    n_err = hcbd_pkg::ERR_BAD;
                                end else begin
                                    n_line  = '0;
                                    n_flags = '0;
                                    n_size  = '0;
                                    if (b_size == '0) begin
                                        n_phase = hcbd_pkg::PH_TRAILER;
                                    end else begin
                                        n_remain = b_size;
                                        n_phase  = hcbd_pkg::PH_DATA;
                                    end
                                end
                            end else if (b_flags[hcbd_pkg::FL_EXT]) begin
                                n_flags[hcbd_pkg::FL_CR] = (r_in_byte == hcbd_pkg::CH_CR);
                            end else if (prev_cr || (line_inc == LINE_LEN_BITS'(1) && !hv.ok)) begin
                                n_err = hcbd_pkg::ERR_BAD;
                            end else if (hv.ok) begin
                                if (b_flags[hcbd_pkg::FL_SPACE]) begin
                                    n_err = hcbd_pkg::ERR_BAD;
                                end else if (b_size[SIZE_BITS-1 -: 4] != 4'd0) begin
                                    n_err = hcbd_pkg::ERR_OVF;
                                end else begin
                                    n_size = {b_size[SIZE_BITS-5:0], hv.val};
                                end
                            end else if (r_in_byte == hcbd_pkg::CH_SPACE) begin
                                n_flags[hcbd_pkg::FL_SPACE] = 1'b1;
                            end else if (r_in_byte == hcbd_pkg::CH_SEMI) begin
                                n_flags[hcbd_pkg::FL_EXT] = 1'b1;
                            end else if (r_in_byte == hcbd_pkg::CH_CR) begin
                                n_flags[hcbd_pkg::FL_CR] = 1'b1;
                            end else begin
                                n_err = hcbd_pkg::ERR_BAD;
                            end
                        end else begin
                            if (prev_cr && r_in_byte == hcbd_pkg::CH_LF) begin
                                n_line  = '0;
                                n_flags = '0;
                                // bare crlf ends the trailer
                                if (line_inc == LINE_LEN_BITS'(2)) begin
                                    n_phase = hcbd_pkg::PH_DONE;
                                end
                            end else begin
                                n_flags = '0;
                                n_flags[hcbd_pkg::FL_CR] = (r_in_byte == hcbd_pkg::CH_CR);
                            end
                        end
                    end
                end
                hcbd_pkg::PH_DATA: begin
                    o_bvalid = 1'b1;
                    o_byte   = r_in_byte;
                    n_remain = b_remain - SIZE_BITS'(1);
                    if (n_remain == '0) begin
                        o_last  = 1'b1;
                        n_phase = hcbd_pkg::PH_DATA_CR;
                    end
                end
                hcbd_pkg::PH_DATA_CR: begin
                    if (r_in_byte == hcbd_pkg::CH_CR) begin
                        n_phase = hcbd_pkg::PH_DATA_LF;
                    end else begin
                        n_err = hcbd_pkg::ERR_CRLF;
                    end
                end
                hcbd_pkg::PH_DATA_LF: begin
                    if (r_in_byte == hcbd_pkg::CH_LF) begin
                        n_phase = hcbd_pkg::PH_SIZE;
                        n_line  = '0;
                        n_flags = '0;
                        n_size  = '0;
                    end else begin
                        n_err = hcbd_pkg::ERR_CRLF;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // control and parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len   <= hcbd_pkg::MAX_LINE_RESET;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= hcbd_pkg::PH_SIZE;
            r_err       <= hcbd_pkg::ERR_NONE;
            r_line      <= '0;
            r_size      <= '0;
            r_remain    <= '0;
            r_flags     <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_max_len <= i_cfg_data;
            end
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_phase     <= n_phase;
                r_err       <= n_err;
                r_line      <= n_line;
                r_size      <= n_size;
                r_remain    <= n_remain;
                r_flags     <= n_flags;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte  <= s_axis_tdata;
            r_in_start <= s_axis_tuser;
        end
        if (advance) begin
            r_out_bvalid <= o_bvalid;
            r_out_byte   <= o_byte;
            r_out_last   <= o_last;
            r_out_done   <= (n_phase == hcbd_pkg::PH_DONE);
            r_out_err    <= n_err;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out_err, r_out_done, r_out_byte};
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_bvalid;

`ifndef NO_ASSERTIONS
    a_last_is_content: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
        else $error("chunk end on a word without content");

    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err != hcbd_pkg::ERR_NONE && !(advance && r_in_start) |=> $stable(r_err))
        else $error("error latch changed without a new message");

    a_data_remain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == hcbd_pkg::PH_DATA |-> r_remain != '0)
        else $error("content phase with nothing left to pass");

    a_idle_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[7:0] == 8'd0)
        else $error("non-content word carries a byte");
`endif

endmodule
